/* src/sld_pkg.sv */
// Shared types, character codes and command literals of the serial line command decoder.
package sld_pkg;

    // Reply codes
    localparam logic [2:0] CODE_LED_ON    = 3'd0;
    localparam logic [2:0] CODE_LED_OFF   = 3'd1;
    localparam logic [2:0] CODE_LED_USAGE = 3'd2;
    localparam logic [2:0] CODE_ADC_READ  = 3'd3;
    localparam logic [2:0] CODE_ADC_RANGE = 3'd4;
    localparam logic [2:0] CODE_HELP      = 3'd5;
    localparam logic [2:0] CODE_VERSION   = 3'd6;
    localparam logic [2:0] CODE_UNKNOWN   = 3'd7;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Command and argument literals, right aligned, first character highest
    localparam logic [31:0] LIT_LED  = {8'h00, "LED"};
    localparam logic [31:0] LIT_ADC  = {8'h00, "ADC"};
    localparam logic [31:0] LIT_HELP = "HELP";
    localparam logic [31:0] LIT_VER  = {8'h00, "VER"};
    localparam logic [31:0] LIT_ON   = {16'h0000, "ON"};
    localparam logic [31:0] LIT_OFF  = {8'h00, "OFF"};
    localparam logic [2:0]  LEN_LED  = 3'd3;
    localparam logic [2:0]  LEN_ADC  = 3'd3;
    localparam logic [2:0]  LEN_HELP = 3'd4;
    localparam logic [2:0]  LEN_VER  = 3'd3;
    localparam logic [2:0]  LEN_ON   = 3'd2;
    localparam logic [2:0]  LEN_OFF  = 3'd3;
    localparam logic [2:0]  POS_MAX  = 3'd7;

    // Controller states
    typedef enum logic {
        ST_COLLECT,
        ST_HOLD
    } t_ctl_state;

    // Number scanner phases
    typedef enum logic [1:0] {
        NP_BLANK,
        NP_DIGITS,
        NP_DONE
    } t_num_phase;

    // Controller to datapath
    typedef struct packed {
        logic take_byte;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic line_nonempty;
    } t_dp_status;

    function automatic logic is_line_end(logic [7:0] ch);
        return (ch == CH_CR) || (ch == CH_LF);
    endfunction

    function automatic logic is_blank(logic [7:0] ch);
        return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    endfunction

    function automatic logic is_digit(logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    // True when ch equals character pos of a literal of length lit_len
    function automatic logic lit_char_ok(logic [31:0] lit, logic [2:0] lit_len,
                                         logic [2:0] pos, logic [7:0] ch);
        logic [1:0] k;
        logic [7:0] want;
        k = 2'(lit_len - pos - 3'd1);
        unique case (k)
            2'd0: want = lit[7:0];
            2'd1: want = lit[15:8];
            2'd2: want = lit[23:16];
            2'd3: want = lit[31:24];
        endcase
        return (pos < lit_len) && (ch == want);
    endfunction

endpackage

/* src/serial_line_command_decoder_core.sv */
// Top level of the serial line command decoder.
// Takes one received byte per request and scans it into the current line as it arrives; a
// CR or LF that ends a non-empty line puts the reply (code, ADC channel, LED level) in the
// output register at that same edge, and it is offered from the next cycle on. Bytes that
// extend a line are taken while a reply waits; a CR or LF is stalled until the previous
// reply has been taken. Up to LINE_CAPACITY bytes count toward a line, later ones are
// dropped, and the text stops at a zero byte.
module serial_line_command_decoder_core import sld_pkg::*; #(
    parameter int LINE_CAPACITY = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_reply_valid,
    input  logic       i_reply_stall,
    output logic [2:0] o_reply_code,
    output logic [2:0] o_adc_channel,
    output logic       o_led_level
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sld_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .i_rx_byte     (i_rx_byte),
        .o_rx_stall    (o_rx_stall),
        .o_reply_valid (o_reply_valid),
        .i_reply_stall (i_reply_stall),
        .i_status      (dp_status),
        .o_cmd         (dp_cmd)
    );

    sld_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_reply_code  (o_reply_code),
        .o_adc_channel (o_adc_channel),
        .o_led_level   (o_led_level)
    );

endmodule

/* src/sld_datapath.sv */
// Line scanner, command decode and reply register of the serial line command decoder.
module sld_datapath import sld_pkg::*; #(
    parameter int LINE_CAPACITY = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_rx_byte,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic [2:0] o_reply_code,
    output logic [2:0] o_adc_channel,
    output logic       o_led_level
);

    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

    // Scanner state
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ended, n_ended;
    logic             r_in_args, n_in_args;
    logic [2:0]       r_wpos, n_wpos;
    logic             r_m_led, n_m_led;
    logic             r_m_adc, n_m_adc;
    logic             r_m_help, n_m_help;
    logic             r_m_ver, n_m_ver;
    logic [2:0]       r_apos, n_apos;
    logic             r_m_on, n_m_on;
    logic             r_m_off, n_m_off;
    t_num_phase       r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [7:0]       r_acc, n_acc;
    logic             r_led, n_led;

    // Reply payload
    logic [2:0] r_code, n_code;
    logic [2:0] r_chan, n_chan;

    logic [7:0] digit_val;
    logic [7:0] adc_value;

    assign digit_val = i_rx_byte - CH_ZERO;

    // Advance the scanner by one byte, or clear it at line end
    always_comb begin
        n_len     = r_len;
        n_ended   = r_ended;
        n_in_args = r_in_args;
        n_wpos    = r_wpos;
        n_m_led   = r_m_led;
        n_m_adc   = r_m_adc;
        n_m_help  = r_m_help;
        n_m_ver   = r_m_ver;
        n_apos    = r_apos;
        n_m_on    = r_m_on;
        n_m_off   = r_m_off;
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_acc     = r_acc;
        if (i_cmd.finish) begin
            n_len     = '0;
            n_ended   = 1'b0;
            n_in_args = 1'b0;
            n_wpos    = 3'd0;
            n_m_led   = 1'b1;
            n_m_adc   = 1'b1;
            n_m_help  = 1'b1;
            n_m_ver   = 1'b1;
            n_apos    = 3'd0;
            n_m_on    = 1'b1;
            n_m_off   = 1'b1;
            n_phase   = NP_BLANK;
            n_neg     = 1'b0;
            n_acc     = 8'd0;
        end else if (i_cmd.take_byte && (r_len < CAP)) begin
            n_len = r_len + 1'b1;
            if (!r_ended) begin
                if (i_rx_byte == CH_NUL) begin
                    // a zero byte ends the line text
                    n_ended = 1'b1;
                end else if (!r_in_args) begin
                    if (i_rx_byte == CH_SPACE) begin
                        n_in_args = 1'b1;
                    end else begin
                        n_m_led  = r_m_led  && lit_char_ok(LIT_LED,  LEN_LED,  r_wpos, i_rx_byte);
                        n_m_adc  = r_m_adc  && lit_char_ok(LIT_ADC,  LEN_ADC,  r_wpos, i_rx_byte);
                        n_m_help = r_m_help && lit_char_ok(LIT_HELP, LEN_HELP, r_wpos, i_rx_byte);
                        n_m_ver  = r_m_ver  && lit_char_ok(LIT_VER,  LEN_VER,  r_wpos, i_rx_byte);
                        n_wpos   = (r_wpos == POS_MAX) ? POS_MAX : r_wpos + 3'd1;
                    end
                end else begin
                    n_m_on  = r_m_on  && lit_char_ok(LIT_ON,  LEN_ON,  r_apos, i_rx_byte);
                    n_m_off = r_m_off && lit_char_ok(LIT_OFF, LEN_OFF, r_apos, i_rx_byte);
                    n_apos  = (r_apos == POS_MAX) ? POS_MAX : r_apos + 3'd1;
                    unique case (r_phase)
                        NP_BLANK: begin
                            if (is_blank(i_rx_byte)) begin
                                n_phase = NP_BLANK;
                            end else if (i_rx_byte == CH_PLUS || i_rx_byte == CH_MINUS) begin
                                n_neg   = (i_rx_byte == CH_MINUS);
                                n_phase = NP_DIGITS;
                            end else if (is_digit(i_rx_byte)) begin
                                n_acc   = digit_val;
                                n_phase = NP_DIGITS;
                            end else begin
                                n_phase = NP_DONE;
                            end
                        end
                        NP_DIGITS: begin
                            if (is_digit(i_rx_byte)) begin
                                n_acc = 8'(r_acc * 8'd10) + digit_val;
                            end else begin
                                n_phase = NP_DONE;
                            end
                        end
                        NP_DONE: begin
                            n_phase = NP_DONE;
                        end
                        default: begin
                            n_phase = NP_DONE;
                        end
                    endcase
                end
            end
        end
    end

    assign adc_value = r_neg ? (8'd0 - r_acc) : r_acc;

    // Decode the finished line
    always_comb begin
        n_led  = r_led;
        n_code = CODE_UNKNOWN;
        n_chan = 3'd0;
        priority if (r_m_led && r_wpos == LEN_LED) begin
            priority if (r_m_on && r_apos == LEN_ON) begin
                n_led  = 1'b1;
                n_code = CODE_LED_ON;
            end else if (r_m_off && r_apos == LEN_OFF) begin
                n_led  = 1'b0;
                n_code = CODE_LED_OFF;
            end else begin
                n_code = CODE_LED_USAGE;
            end
        end else if (r_m_adc && r_wpos == LEN_ADC) begin
            if (adc_value > 8'd7) begin
                n_code = CODE_ADC_RANGE;
            end else begin
                n_code = CODE_ADC_READ;
                n_chan = adc_value[2:0];
            end
        end else if (r_m_help && r_wpos == LEN_HELP) begin
            n_code = CODE_HELP;
        end else if (r_m_ver && r_wpos == LEN_VER) begin
            n_code = CODE_VERSION;
        end else begin
            n_code = CODE_UNKNOWN;
        end
    end

    // Hold scanner and LED state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ended   <= 1'b0;
            r_in_args <= 1'b0;
            r_wpos    <= 3'd0;
            r_m_led   <= 1'b1;
            r_m_adc   <= 1'b1;
            r_m_help  <= 1'b1;
            r_m_ver   <= 1'b1;
            r_apos    <= 3'd0;
            r_m_on    <= 1'b1;
            r_m_off   <= 1'b1;
            r_phase   <= NP_BLANK;
            r_neg     <= 1'b0;
            r_acc     <= 8'd0;
            r_led     <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_ended   <= n_ended;
            r_in_args <= n_in_args;
            r_wpos    <= n_wpos;
            r_m_led   <= n_m_led;
            r_m_adc   <= n_m_adc;
            r_m_help  <= n_m_help;
            r_m_ver   <= n_m_ver;
            r_apos    <= n_apos;
            r_m_on    <= n_m_on;
            r_m_off   <= n_m_off;
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_acc     <= n_acc;
            if (i_cmd.finish) begin
                r_led <= n_led;
            end
        end
    end

    // Capture the reply payload at line end
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_code <= n_code;
            r_chan <= n_chan;
        end
    end

    assign o_status.line_nonempty = (r_len != '0);
    assign o_reply_code  = r_code;
    assign o_adc_channel = r_chan;
    assign o_led_level   = r_led;

endmodule

/* src/sld_ctrl.sv */
// Handshake controller of the serial line command decoder.
module sld_ctrl import sld_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_rx_stall,
    output logic       o_reply_valid,
    input  logic       i_reply_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_ctl_state r_state, n_state;
    logic       line_end;
    logic       in_fire;

    assign line_end = is_line_end(i_rx_byte);

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_rx_stall      = 1'b0;
        o_reply_valid   = 1'b0;
        o_cmd.take_byte = 1'b0;
        o_cmd.finish    = 1'b0;
        in_fire         = 1'b0;
        unique case (r_state)
            ST_COLLECT: begin
                in_fire         = i_rx_valid;
                o_cmd.take_byte = in_fire && !line_end;
                o_cmd.finish    = in_fire && line_end && i_status.line_nonempty;
                if (o_cmd.finish) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // keep taking line bytes; stall a line end until the reply drains
                o_reply_valid   = 1'b1;
                o_rx_stall      = line_end;
                in_fire         = i_rx_valid && !line_end;
                o_cmd.take_byte = in_fire;
                if (!i_reply_stall) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

endmodule

/* src/sld_checker.sv */
// Port-level checks of the serial line command decoder, bound to the top level.
module sld_checker import sld_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_valid,
    input logic       o_rx_stall,
    input logic [7:0] i_rx_byte,
    input logic       o_reply_valid,
    input logic       i_reply_stall,
    input logic [2:0] o_reply_code,
    input logic [2:0] o_adc_channel,
    input logic       o_led_level
);

    // A stalled reply holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply_valid && i_reply_stall |=>
            o_reply_valid && $stable(o_reply_code) && $stable(o_adc_channel)
            && $stable(o_led_level))
        else $error("stalled reply changed");

    // A reply appears only after a line end request was taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_reply_valid) |->
            $past(i_rx_valid && !o_rx_stall && (i_rx_byte == CH_CR || i_rx_byte == CH_LF)))
        else $error("reply without line end");

    // Input stalls only while a reply waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_reply_valid)
        else $error("input stalled with no pending reply");

    // Channel is zero unless the reply is an ADC read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply_valid && o_reply_code != CODE_ADC_READ |-> o_adc_channel == 3'd0)
        else $error("channel set on non-ADC reply");

    // LED level agrees with an LED on or off reply
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply_valid && (o_reply_code == CODE_LED_ON || o_reply_code == CODE_LED_OFF)
            |-> o_led_level == (o_reply_code == CODE_LED_ON))
        else $error("LED level disagrees with reply");

endmodule

bind serial_line_command_decoder_core sld_checker u_sld_checker (.*);

/* test/testbench.sv */
// Self-checking testbench of the serial line command decoder: directed lines, then random traffic.
module testbench;
    import sld_pkg::*;

    localparam int LINE_CAP     = 63;
    localparam int RANDOM_BYTES = 1350;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [2:0] code;
        logic [2:0] chan;
        logic       led;
    } t_reply;

    // One directed line; '^' stands for a zero byte and '~' for 0xFF
    typedef struct {
        string  text;
        bit     typed;
        t_reply want;
    } t_dir_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       reply_valid;
    logic       reply_stall = 1'b0;
    logic [2:0] reply_code;
    logic [2:0] adc_channel;
    logic       led_level;

    // Predicted decoder state
    logic [7:0] pred_line [LINE_CAP];
    int         pred_len = 0;
    logic       pred_led = 1'b0;

    t_reply     reply_q [$];
    logic [7:0] line_q [$];
    int         mismatch_count = 0;
    int         bytes_sent = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_req = 1'b0;

    t_dir_row dir_rows [22] = '{
        '{"\015",            1'b0, '{CODE_UNKNOWN,   3'd0, 1'b0}},
        '{"LED ON\015",      1'b1, '{CODE_LED_ON,    3'd0, 1'b1}},
        '{"LED OFF\n",       1'b1, '{CODE_LED_OFF,   3'd0, 1'b0}},
        '{"LED on\015",      1'b1, '{CODE_LED_USAGE, 3'd0, 1'b0}},
        '{"LED\015",         1'b1, '{CODE_LED_USAGE, 3'd0, 1'b0}},
        '{"LED ON\015\n",    1'b1, '{CODE_LED_ON,    3'd0, 1'b1}},
        '{"ADC 7\015",       1'b1, '{CODE_ADC_READ,  3'd7, 1'b1}},
        '{"ADC 8\015",       1'b1, '{CODE_ADC_RANGE, 3'd0, 1'b1}},
        '{"ADC \t +3x\015",  1'b0, '{CODE_UNKNOWN,   3'd0, 1'b0}},
        '{"ADC -249\n",      1'b0, '{CODE_UNKNOWN,   3'd0, 1'b0}},
        '{"ADC 263\015",     1'b0, '{CODE_UNKNOWN,   3'd0, 1'b0}},
        '{"ADC\015",         1'b0, '{CODE_UNKNOWN,   3'd0, 1'b0}},
        '{"ADC -\015",       1'b0, '{CODE_UNKNOWN,   3'd0, 1'b0}},
        '{"HELP\015",        1'b1, '{CODE_HELP,      3'd0, 1'b1}},
        '{"VER\n",           1'b1, '{CODE_VERSION,   3'd0, 1'b1}},
        '{"VERX\015",        1'b1, '{CODE_UNKNOWN,   3'd0, 1'b1}},
        '{"^LED OFF\015",    1'b1, '{CODE_UNKNOWN,   3'd0, 1'b1}},
        '{"LED OFF^X\015",   1'b0, '{CODE_UNKNOWN,   3'd0, 1'b0}},
        '{"~\015",           1'b1, '{CODE_UNKNOWN,   3'd0, 1'b0}},
        '{" HELP\015",       1'b1, '{CODE_UNKNOWN,   3'd0, 1'b0}},
        '{"ADC 000000000000000000000000000000000000000000000000000000000009\015",
                             1'b0, '{CODE_UNKNOWN,   3'd0, 1'b0}},
        '{"LED  ON\015",     1'b0, '{CODE_UNKNOWN,   3'd0, 1'b0}}
    };

    serial_line_command_decoder_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_rx_valid    (rx_valid),
        .o_rx_stall    (rx_stall),
        .i_rx_byte     (rx_byte),
        .o_reply_valid (reply_valid),
        .i_reply_stall (reply_stall),
        .o_reply_code  (reply_code),
        .o_adc_channel (adc_channel),
        .o_led_level   (led_level)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // True when line bytes [from, to) spell the literal exactly
    function automatic bit span_is(int from, int to, string lit);
        if (to - from != lit.len())
            return 1'b0;
        for (int i = 0; i < lit.len(); i++) begin
            if (pred_line[from + i] != 8'(lit[i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit is_white(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Decimal value of bytes [from, to), modulo 256, with optional sign
    function automatic logic [7:0] parse_channel(int from, int to);
        int         i;
        bit         neg;
        logic [7:0] acc;
        i = from;
        neg = 1'b0;
        acc = 8'd0;
        while (i < to && is_white(pred_line[i]))
            i++;
        if (i < to && (pred_line[i] == CH_PLUS || pred_line[i] == CH_MINUS)) begin
            neg = (pred_line[i] == CH_MINUS);
            i++;
        end
        while (i < to && pred_line[i] >= CH_ZERO && pred_line[i] <= CH_NINE) begin
            acc = acc * 8'd10 + (pred_line[i] - CH_ZERO);
            i++;
        end
        if (neg)
            acc = 8'd0 - acc;
        return acc;
    endfunction

    // Split the collected line and decode the command word
    function automatic t_reply decode_command();
        int         stop;
        int         split;
        int         arg_from;
        logic [7:0] v;
        t_reply     r;
        stop = 0;
        while (stop < pred_len && pred_line[stop] != CH_NUL)
            stop++;
        split = 0;
        while (split < stop && pred_line[split] != CH_SPACE)
            split++;
        arg_from = (split < stop) ? split + 1 : stop;
        r.chan = 3'd0;
        if (span_is(0, split, "LED")) begin
            if (span_is(arg_from, stop, "ON")) begin
                pred_led = 1'b1;
                r.code = CODE_LED_ON;
            end else if (span_is(arg_from, stop, "OFF")) begin
                pred_led = 1'b0;
                r.code = CODE_LED_OFF;
            end else begin
                r.code = CODE_LED_USAGE;
            end
        end else if (span_is(0, split, "ADC")) begin
            v = parse_channel(arg_from, stop);
            if (v > 8'd7) begin
                r.code = CODE_ADC_RANGE;
            end else begin
                r.code = CODE_ADC_READ;
                r.chan = v[2:0];
            end
        end else if (span_is(0, split, "HELP")) begin
            r.code = CODE_HELP;
        end else if (span_is(0, split, "VER")) begin
            r.code = CODE_VERSION;
        end else begin
            r.code = CODE_UNKNOWN;
        end
        r.led = pred_led;
        return r;
    endfunction

    // Advance the predicted line by one byte; fire on a non-empty line end
    function automatic void advance_line(input logic [7:0] b, output bit fired,
                                         output t_reply r);
        fired = 1'b0;
        r = '0;
        if (b == CH_CR || b == CH_LF) begin
            if (pred_len != 0) begin
                r = decode_command();
                fired = 1'b1;
                pred_len = 0;
            end
        end else if (pred_len < LINE_CAP) begin
            pred_line[pred_len] = b;
            pred_len++;
        end
    endfunction

    // Offer one byte, wait for its request to be taken, then predict
    task automatic send_byte(input logic [7:0] b, input bit use_typed, input t_reply typed);
        bit     fired;
        t_reply r;
        while ($urandom_range(99) < send_idle_pct) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (rx_stall !== 1'b0)
            @(posedge clk);
        bytes_sent++;
        advance_line(b, fired, r);
        if (fired)
            reply_q.push_back(use_typed ? typed : r);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(8'(s[i]));
    endtask

    function automatic logic [7:0] rand_printable();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    task automatic flush_line();
        foreach (line_q[i])
            send_byte(line_q[i], 1'b0, '0);
        line_q.delete();
    endtask

    // Build one random line, mostly well-formed commands with random content
    task automatic make_random_line();
        int     kind;
        int     n;
        string  led_args [6] = '{" ON", " OFF", " ON", " OF", " OFF ", " ONN"};
        kind = $urandom_range(99);
        if (kind < 18) begin
            push_text("LED");
            if ($urandom_range(4) == 0) begin
                line_q.push_back(CH_SPACE);
                line_q.push_back(8'($urandom_range(255)));
            end else begin
                push_text(led_args[$urandom_range(5)]);
            end
        end else if (kind < 45) begin
            push_text("ADC");
            if ($urandom_range(9) != 0)
                line_q.push_back(CH_SPACE);
            n = $urandom_range(2);
            repeat (n) begin
                case ($urandom_range(3))
                    0: line_q.push_back(CH_SPACE);
                    1: line_q.push_back(CH_TAB);
                    2: line_q.push_back(8'h0B);
                    default: line_q.push_back(8'h0C);
                endcase
            end
            case ($urandom_range(3))
                2: line_q.push_back(CH_PLUS);
                3: line_q.push_back(CH_MINUS);
                default: ;
            endcase
            n = ($urandom_range(2) == 0) ? $urandom_range(4) : 1;
            repeat (n)
                line_q.push_back(CH_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(3) == 0)
                line_q.push_back(rand_printable());
        end else if (kind < 53) begin
            push_text("HELP");
            if ($urandom_range(3) == 0)
                push_text(" x");
        end else if (kind < 61) begin
            push_text("VER");
            if ($urandom_range(3) == 0)
                push_text(" 2");
        end else if (kind < 71) begin
            n = $urandom_range(1, 5);
            repeat (n)
                line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            if ($urandom_range(1) == 0) begin
                line_q.push_back(CH_SPACE);
                line_q.push_back(rand_printable());
            end
        end else if (kind < 83) begin
            n = $urandom_range(1, 8);
            repeat (n)
                line_q.push_back(8'($urandom_range(255)));
        end else if (kind < 88) begin
            // Long line of 60 to 90 bytes: any tail past capacity is dropped
            case ($urandom_range(2))
                0: push_text("ADC 3");
                1: push_text("LED ON");
                default: ;
            endcase
            n = $urandom_range(60, 90);
            while (line_q.size() < n)
                line_q.push_back(($urandom_range(4) == 0) ? CH_SPACE : rand_printable());
        end else if (kind < 94) begin
            // Zero byte cuts the text short
            case ($urandom_range(2))
                0: push_text("LED ON");
                1: push_text("ADC 5");
                default: ;
            endcase
            line_q.push_back(CH_NUL);
            line_q.push_back(rand_printable());
        end
        line_q.push_back(($urandom_range(1) == 1) ? CH_CR : CH_LF);
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Drive the reply stall; a long hold-off is counted here when requested
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                reply_stall <= 1'b1;
                hold_left--;
            end else begin
                reply_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Compare each taken reply with the oldest expectation
    always @(posedge clk) begin
        t_reply want;
        if (rst_n && reply_valid === 1'b1 && reply_stall == 1'b0) begin
            if (reply_q.size() == 0) begin
                report_mismatch("reply with nothing pending, code", 8'(reply_code), 8'd0);
            end else begin
                want = reply_q.pop_front();
                if (reply_code !== want.code)
                    report_mismatch("reply_code", 8'(reply_code), 8'(want.code));
                if (adc_channel !== want.chan)
                    report_mismatch("adc_channel", 8'(adc_channel), 8'(want.chan));
                if (led_level !== want.led)
                    report_mismatch("led_level", 8'(led_level), 8'(want.led));
            end
        end
    end

    initial begin
        #(12 * LIMIT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [7:0] c;
        send_idle_pct = 8;
        recv_idle_pct = 53;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_rows[i]) begin
            for (int j = 0; j < dir_rows[i].text.len(); j++) begin
                c = 8'(dir_rows[i].text[j]);
                if (c == "^")
                    c = CH_NUL;
                else if (c == "~")
                    c = 8'hFF;
                send_byte(c, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random traffic in three idle settings
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES / 3) begin
            make_random_line();
            flush_line();
        end
        send_idle_pct = 53;
        recv_idle_pct = 8;
        while (bytes_sent < 2 * RANDOM_BYTES / 3) begin
            make_random_line();
            flush_line();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Hold the receiver off while line ends keep coming
        hold_req = 1'b1;
        repeat (8)
            push_text("VER\015");
        flush_line();

        while (bytes_sent < RANDOM_BYTES) begin
            make_random_line();
            flush_line();
        end
        rx_valid <= 1'b0;

        // Drain outstanding replies
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/sld_pkg.sv
src/sld_datapath.sv
src/sld_ctrl.sv
src/serial_line_command_decoder_core.sv
src/sld_checker.sv
test/testbench.sv
